// ===== design/bounded_move_to_front_list_macros.svh =====
// Assertion macros for the checker file of the MRU list block.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef BOUNDED_MOVE_TO_FRONT_LIST_MACROS_SVH
`define BOUNDED_MOVE_TO_FRONT_LIST_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset
`define MTF_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset
`define MTF_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/mtf_pkg.sv =====
// Package of the MRU list block: sizes, command and state codes, memory request.
// No dependencies; used by every module of the block.
package mtf_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_W     = 16;
  localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int CMD_W    = 2;
  localparam int ITEM_W   = 16;
  localparam int INDEX_W  = 8;
  localparam int LEN_W    = 5;
  localparam int HS_W     = 5;
  localparam logic [HS_W-1:0] HS_RESET = 5'd10;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_READ   = 2'd3
  } mtf_cmd_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_PROC,
    S_EMIT,
    S_DONE
  } mtf_state_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [ID_W-1:0]  wdata;
    logic [IDX_W-1:0] raddr;
  } mtf_mem_req_t;

endpackage

// ===== design/mtf_mem.sv =====
// Entry store of the MRU list: one write and one registered read per cycle.
// Depends on mtf_pkg for depth, widths and the request struct.
module mtf_mem (
  input  logic                  clk,
  input  mtf_pkg::mtf_mem_req_t req,
  output logic [mtf_pkg::ID_W-1:0] rdata
);

  logic [mtf_pkg::ID_W-1:0] mem [mtf_pkg::DEPTH];
  logic [mtf_pkg::ID_W-1:0] rdata_r;

  // Write the addressed entry and register the read port
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata_r <= mem[req.raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/mtf_core.sv =====
// Sequencer of the MRU list: walks the stored entries one per step through a
// single compare unit, rewriting them in place. Depends on mtf_pkg and mtf_mem.
module mtf_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mtf_pkg::CNT_W-1:0]     eff,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtf_pkg::CMD_W-1:0]     in_command,
  input  logic [mtf_pkg::ITEM_W-1:0]    in_item_id,
  input  logic [mtf_pkg::INDEX_W-1:0]   in_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_changed,
  output logic                          out_found,
  output logic [mtf_pkg::ITEM_W-1:0]    out_read_item,
  output logic [mtf_pkg::LEN_W-1:0]     out_list_length,
  output logic [mtf_pkg::LEN_W-1:0]     out_effective_size,
  output mtf_pkg::mtf_mem_req_t         mem_req,
  input  logic [mtf_pkg::ID_W-1:0]      mem_rdata
);

  localparam int CNT_W = mtf_pkg::CNT_W;
  localparam int IDX_W = mtf_pkg::IDX_W;
  localparam int ID_W  = mtf_pkg::ID_W;

  mtf_pkg::mtf_state_t state_r, state_nxt;
  mtf_pkg::mtf_cmd_t   cmd_r, cmd_nxt, in_cmd;

  logic [ID_W-1:0]              id_r, id_nxt;
  logic [ID_W-1:0]              carry_r, carry_nxt;
  logic [mtf_pkg::INDEX_W-1:0]  idx_r, idx_nxt;
  logic [CNT_W-1:0]             eff_r, eff_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic [CNT_W-1:0]             rp_r, rp_nxt;
  logic [CNT_W-1:0]             wp_r, wp_nxt;
  logic [CNT_W-1:0]             k_r, k_nxt;
  logic                         hit_r, hit_nxt;
  logic                         chg_r, chg_nxt;
  logic                         fnd_r, fnd_nxt;
  logic [ID_W-1:0]              rd_r, rd_nxt;

  logic                         ov_r, ov_nxt;
  logic                         ochg_r, ochg_nxt;
  logic                         ofnd_r, ofnd_nxt;
  logic [mtf_pkg::ITEM_W-1:0]   oitem_r, oitem_nxt;
  logic [mtf_pkg::LEN_W-1:0]    olen_r, olen_nxt;
  logic [mtf_pkg::LEN_W-1:0]    oeff_r, oeff_nxt;

  logic             eq, skip, last, keep, out_free;
  logic [CNT_W-1:0] rp_inc, wp_inc, k_inc;

  // Shared compare unit and step bookkeeping
  assign in_cmd   = mtf_pkg::mtf_cmd_t'(in_command);
  assign eq       = (mem_rdata == id_r);
  assign skip     = eq && !hit_r;
  assign rp_inc   = CNT_W'(rp_r + 1'b1);
  assign wp_inc   = CNT_W'(wp_r + 1'b1);
  assign k_inc    = CNT_W'(k_r + 1'b1);
  assign last     = (rp_inc == cnt_r);
  assign keep     = (k_r != eff_r);
  assign out_free = !ov_r || !out_stall;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtf_pkg::S_IDLE: begin
        if (in_valid) begin
          unique case (in_cmd)
            mtf_pkg::CMD_ADD:    state_nxt = (cnt_r == '0) ? mtf_pkg::S_EMIT : mtf_pkg::S_READ;
            mtf_pkg::CMD_REMOVE: state_nxt = (cnt_r == '0) ? mtf_pkg::S_DONE : mtf_pkg::S_READ;
            mtf_pkg::CMD_CLEAR:  state_nxt = mtf_pkg::S_DONE;
            mtf_pkg::CMD_READ:   state_nxt = (in_index < cnt_r) ? mtf_pkg::S_READ
                                                                 : mtf_pkg::S_DONE;
          endcase
        end
      end
      mtf_pkg::S_READ: state_nxt = mtf_pkg::S_PROC;
      mtf_pkg::S_PROC: begin
        unique case (cmd_r)
          mtf_pkg::CMD_ADD: begin
            if (skip && rp_r == '0) begin
              state_nxt = mtf_pkg::S_DONE;
            end else begin
              state_nxt = last ? mtf_pkg::S_EMIT : mtf_pkg::S_READ;
            end
          end
          mtf_pkg::CMD_REMOVE: state_nxt = last ? mtf_pkg::S_DONE : mtf_pkg::S_READ;
          mtf_pkg::CMD_CLEAR:  state_nxt = mtf_pkg::S_DONE;
          mtf_pkg::CMD_READ:   state_nxt = mtf_pkg::S_DONE;
        endcase
      end
      mtf_pkg::S_EMIT: state_nxt = mtf_pkg::S_DONE;
      mtf_pkg::S_DONE: state_nxt = out_free ? mtf_pkg::S_IDLE : mtf_pkg::S_DONE;
      default:         state_nxt = mtf_pkg::S_IDLE;
    endcase
  end

  // Memory port and input handshake
  always_comb begin
    in_stall      = (state_r != mtf_pkg::S_IDLE);
    mem_req.raddr = (cmd_r == mtf_pkg::CMD_READ) ? idx_r[IDX_W-1:0] : rp_r[IDX_W-1:0];
    mem_req.waddr = wp_r[IDX_W-1:0];
    mem_req.wdata = carry_r;
    mem_req.we    = 1'b0;
    unique case (state_r)
      mtf_pkg::S_PROC: begin
        if (cmd_r == mtf_pkg::CMD_ADD) begin
          mem_req.we = !skip && keep;
        end else if (cmd_r == mtf_pkg::CMD_REMOVE) begin
          mem_req.we    = !skip;
          mem_req.wdata = mem_rdata;
        end
      end
      mtf_pkg::S_EMIT: mem_req.we = keep;
      default:         mem_req.we = 1'b0;
    endcase
  end

  // Datapath and result registers
  always_comb begin
    cmd_nxt   = cmd_r;
    id_nxt    = id_r;
    carry_nxt = carry_r;
    idx_nxt   = idx_r;
    eff_nxt   = eff_r;
    cnt_nxt   = cnt_r;
    rp_nxt    = rp_r;
    wp_nxt    = wp_r;
    k_nxt     = k_r;
    hit_nxt   = hit_r;
    chg_nxt   = chg_r;
    fnd_nxt   = fnd_r;
    rd_nxt    = rd_r;
    ov_nxt    = ov_r && out_stall;
    ochg_nxt  = ochg_r;
    ofnd_nxt  = ofnd_r;
    oitem_nxt = oitem_r;
    olen_nxt  = olen_r;
    oeff_nxt  = oeff_r;
    unique case (state_r)
      mtf_pkg::S_IDLE: begin
        // Capture the beat and open a fresh pass
        if (in_valid) begin
          cmd_nxt   = in_cmd;
          id_nxt    = in_item_id[ID_W-1:0];
          carry_nxt = in_item_id[ID_W-1:0];
          idx_nxt   = in_index;
          eff_nxt   = eff;
          rp_nxt    = '0;
          wp_nxt    = '0;
          k_nxt     = '0;
          hit_nxt   = 1'b0;
          chg_nxt   = 1'b0;
          fnd_nxt   = 1'b0;
          rd_nxt    = '0;
          if (in_cmd == mtf_pkg::CMD_CLEAR) begin
            cnt_nxt = '0;
            chg_nxt = (cnt_r != '0);
          end
        end
      end
      mtf_pkg::S_READ: begin
      end
      mtf_pkg::S_PROC: begin
        unique case (cmd_r)
          mtf_pkg::CMD_ADD: begin
            // Drop the earlier copy, else push the carried entry one place down
            if (skip) begin
              hit_nxt = 1'b1;
            end else begin
              if (keep) begin
                wp_nxt = wp_inc;
              end
              carry_nxt = mem_rdata;
              k_nxt     = k_inc;
            end
            rp_nxt = rp_inc;
          end
          mtf_pkg::CMD_REMOVE: begin
            // Close the gap left by the removed entry
            if (skip) begin
              hit_nxt = 1'b1;
            end else begin
              wp_nxt = wp_inc;
            end
            rp_nxt = rp_inc;
            if (last) begin
              cnt_nxt = skip ? wp_r : wp_inc;
              chg_nxt = skip || hit_r;
            end
          end
          mtf_pkg::CMD_CLEAR: begin
          end
          mtf_pkg::CMD_READ: begin
            fnd_nxt = 1'b1;
            rd_nxt  = mem_rdata;
          end
        endcase
      end
      mtf_pkg::S_EMIT: begin
        // Write the last carried entry unless it sits at the size limit
        cnt_nxt = keep ? wp_inc : wp_r;
        chg_nxt = 1'b1;
      end
      mtf_pkg::S_DONE: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          ochg_nxt  = chg_r;
          ofnd_nxt  = fnd_r;
          oitem_nxt = mtf_pkg::ITEM_W'(rd_r);
          olen_nxt  = mtf_pkg::LEN_W'(cnt_r);
          oeff_nxt  = mtf_pkg::LEN_W'(eff_r);
        end
      end
      default: begin
      end
    endcase
  end

  // Control state with reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mtf_pkg::S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    id_r    <= id_nxt;
    carry_r <= carry_nxt;
    idx_r   <= idx_nxt;
    eff_r   <= eff_nxt;
    rp_r    <= rp_nxt;
    wp_r    <= wp_nxt;
    k_r     <= k_nxt;
    hit_r   <= hit_nxt;
    chg_r   <= chg_nxt;
    fnd_r   <= fnd_nxt;
    rd_r    <= rd_nxt;
    ochg_r  <= ochg_nxt;
    ofnd_r  <= ofnd_nxt;
    oitem_r <= oitem_nxt;
    olen_r  <= olen_nxt;
    oeff_r  <= oeff_nxt;
  end

  assign out_valid          = ov_r;
  assign out_changed        = ochg_r;
  assign out_found          = ofnd_r;
  assign out_read_item      = oitem_r;
  assign out_list_length    = olen_r;
  assign out_effective_size = oeff_r;

endmodule

// ===== design/bounded_move_to_front_list.sv =====
// Bounded move-to-front list of item identifiers, most recent at position 0.
// Channels: in_* (command, item_id, index) and out_* results use valid/stall;
// a beat moves when valid is high and stall is low. cfg_* writes the capacity
// register with valid/ready; cfg_ready is always high. Write it only while idle.
// Each command beat gives exactly one result beat.
// With n the stored length, an add or a remove reads the n entries in turn from
// the entry memory's single registered read port and runs each through the one
// compare unit; an add then writes the last carried entry if it fits, and an add
// of the head item stops at the first compare. A read inside the list reads its
// one entry; clear and a read outside it go straight to the result. in_stall is
// high from the accepting edge until the result is loaded into the output
// register, so one command is at work at a time; the next command is taken while
// an earlier result waits.
// A stalled result holds in the output register; a finished result waits for it.
// Reset empties the list and sets the capacity to 10; memory is not cleared.
// Depends on mtf_pkg, mtf_mem and mtf_core.
module bounded_move_to_front_list (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mtf_pkg::CMD_W-1:0]     in_command,
  input  logic [mtf_pkg::ITEM_W-1:0]    in_item_id,
  input  logic [mtf_pkg::INDEX_W-1:0]   in_index,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_changed,
  output logic                          out_found,
  output logic [mtf_pkg::ITEM_W-1:0]    out_read_item,
  output logic [mtf_pkg::LEN_W-1:0]     out_list_length,
  output logic [mtf_pkg::LEN_W-1:0]     out_effective_size,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtf_pkg::HS_W-1:0]      cfg_data
);

  logic [mtf_pkg::HS_W-1:0]  hs_r, hs_nxt;
  logic [mtf_pkg::CNT_W-1:0] eff;
  mtf_pkg::mtf_mem_req_t     mem_req;
  logic [mtf_pkg::ID_W-1:0]  mem_rdata;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;
  assign hs_nxt    = (cfg_valid && cfg_ready) ? cfg_data : hs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r <= mtf_pkg::HS_RESET;
    end else begin
      hs_r <= hs_nxt;
    end
  end

  // Raise zero to one and saturate at the depth
  always_comb begin
    if (hs_r == '0) begin
      eff = mtf_pkg::CNT_W'(1);
    end else if (int'(hs_r) > mtf_pkg::DEPTH) begin
      eff = mtf_pkg::CNT_W'(mtf_pkg::DEPTH);
    end else begin
      eff = mtf_pkg::CNT_W'(hs_r);
    end
  end

  mtf_core u_core (
    .clk                (clk),
    .rst_n              (rst_n),
    .eff                (eff),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_item_id         (in_item_id),
    .in_index           (in_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_changed        (out_changed),
    .out_found          (out_found),
    .out_read_item      (out_read_item),
    .out_list_length    (out_list_length),
    .out_effective_size (out_effective_size),
    .mem_req            (mem_req),
    .mem_rdata          (mem_rdata)
  );

  mtf_mem u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

endmodule

// ===== design/mtf_chk.sv =====
// Port checker of the MRU list block, bound to the top level.
// Depends on mtf_pkg and bounded_move_to_front_list_macros.svh.
`include "bounded_move_to_front_list_macros.svh"

module mtf_chk (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        out_changed,
  input logic                        out_found,
  input logic [mtf_pkg::ITEM_W-1:0]  out_read_item,
  input logic [mtf_pkg::LEN_W-1:0]   out_list_length,
  input logic [mtf_pkg::LEN_W-1:0]   out_effective_size
);

  // Hold a stalled result beat
  `MTF_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_read_item) && $stable(out_list_length), "stalled result changed")

  // A miss returns a zero item
  `MTF_ASSERT_IMP(a_miss_zero, out_valid && !out_found, out_read_item == '0, "read_item not zero on a miss")

  // A hit needs a non-empty list and never changes it
  `MTF_ASSERT_IMP(a_hit_shape, out_valid && out_found, (out_list_length != '0) && !out_changed, "hit on an empty list or with a change")

  // Size is non-zero; length and size stay within the depth
  `MTF_ASSERT_IMP(a_size_range, out_valid, (out_effective_size != '0) && (int'(out_list_length) <= mtf_pkg::DEPTH) && (int'(out_effective_size) <= mtf_pkg::DEPTH), "length or size out of range")

endmodule

bind bounded_move_to_front_list mtf_chk u_chk (.*);

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for the bounded move-to-front list: directed and random command beats,
// each result checked against an MRU list model kept in the bench.
// Depends on mtf_pkg and bounded_move_to_front_list.
module tb_top;

  localparam int DEPTH          = mtf_pkg::DEPTH;
  localparam int ID_W           = mtf_pkg::ID_W;
  localparam int CMD_W          = mtf_pkg::CMD_W;
  localparam int ITEM_W         = mtf_pkg::ITEM_W;
  localparam int INDEX_W        = mtf_pkg::INDEX_W;
  localparam int LEN_W          = mtf_pkg::LEN_W;
  localparam int HS_W           = mtf_pkg::HS_W;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int MAX_REPORTS    = 10;
  localparam int POOL_MAX       = 24;
  localparam int PHASE_BEATS    = 110;

  typedef struct packed {
    logic               changed;
    logic               found;
    logic [ITEM_W-1:0]  read_item;
    logic [LEN_W-1:0]   list_length;
    logic [LEN_W-1:0]   effective_size;
  } mru_result_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_command;
  logic [ITEM_W-1:0]   in_item_id;
  logic [INDEX_W-1:0]  in_index;
  logic                out_valid;
  logic                out_stall;
  logic                out_changed;
  logic                out_found;
  logic [ITEM_W-1:0]   out_read_item;
  logic [LEN_W-1:0]    out_list_length;
  logic [LEN_W-1:0]    out_effective_size;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [HS_W-1:0]     cfg_data;

  // MRU list model: stored ids, length and the capacity register
  logic [ID_W-1:0]     mru_ids [DEPTH];
  int                  mru_len;
  logic [HS_W-1:0]     mru_history;
  mru_result_t         mru_expected [$];

  // Run bookkeeping
  int                  fail_count    = 0;
  int                  quiet_cycles  = 0;
  int                  n_settings    = 1;
  int                  read_hits     = 0;
  int                  beats_per_cmd [4] = '{0, 0, 0, 0};
  bit                  no_idle       = 1'b0;
  bit                  hold_pending  = 1'b0;
  logic [ITEM_W-1:0]   id_pool [POOL_MAX];
  int                  pool_size     = 1;

  bounded_move_to_front_list DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_command         (in_command),
    .in_item_id         (in_item_id),
    .in_index           (in_index),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_changed        (out_changed),
    .out_found          (out_found),
    .out_read_item      (out_read_item),
    .out_list_length    (out_list_length),
    .out_effective_size (out_effective_size),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_data           (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Position of an id in the model list, or the length when absent
  function automatic int mru_find(input logic [ID_W-1:0] id);
    for (int i = 0; i < mru_len; i++)
      if (mru_ids[i] == id) return i;
    return mru_len;
  endfunction

  // Delete one position, closing the gap towards the head
  function automatic void mru_delete(input int pos);
    for (int i = pos; i + 1 < mru_len; i++) mru_ids[i] = mru_ids[i + 1];
    mru_len--;
  endfunction

  // Apply one command beat to the model and return the result it gives
  function automatic mru_result_t mru_apply(input logic [CMD_W-1:0] cmd,
                                            input logic [ITEM_W-1:0] id,
                                            input logic [INDEX_W-1:0] idx);
    mru_result_t     res;
    logic [ID_W-1:0] shifted [DEPTH + 1];
    int              eff;
    int              pos;
    int              n;
    res = '0;
    eff = (mru_history == 0) ? 1 : ((mru_history > DEPTH) ? DEPTH : int'(mru_history));
    case (cmd)
      mtf_pkg::CMD_ADD: begin
        // an add of the head item leaves the list as it is
        if (!(mru_len > 0 && mru_ids[0] == id)) begin
          pos = mru_find(id);
          if (pos < mru_len) mru_delete(pos);
          shifted[0] = id;
          for (int i = 0; i < mru_len; i++) shifted[i + 1] = mru_ids[i];
          n = mru_len + 1;
          // drop the one entry pushed to the capacity position
          if (eff < n) begin
            for (int i = eff; i + 1 < n; i++) shifted[i] = shifted[i + 1];
            n--;
          end
          if (n > DEPTH) n = DEPTH;
          for (int i = 0; i < n; i++) mru_ids[i] = shifted[i];
          mru_len = n;
          res.changed = 1'b1;
        end
      end
      mtf_pkg::CMD_REMOVE: begin
        pos = mru_find(id);
        if (pos < mru_len) begin
          mru_delete(pos);
          res.changed = 1'b1;
        end
      end
      mtf_pkg::CMD_CLEAR: begin
        if (mru_len > 0) begin
          mru_len = 0;
          res.changed = 1'b1;
        end
      end
      mtf_pkg::CMD_READ: begin
        if (idx < mru_len) begin
          res.found     = 1'b1;
          res.read_item = mru_ids[idx];
        end
      end
      default: ;
    endcase
    res.list_length    = LEN_W'(mru_len);
    res.effective_size = LEN_W'(eff);
    return res;
  endfunction

  // Check result beats, predict accepted command beats, track register writes
  always @(posedge clk) begin : monitor
    mru_result_t got;
    mru_result_t want;
    if (!rst_n) begin
      mru_len     = 0;
      mru_history = mtf_pkg::HS_RESET;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_changed, out_found, out_read_item, out_list_length,
                out_effective_size};
        if (mru_expected.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result beat with nothing expected: %h", $time, got);
        end else begin
          want = mru_expected.pop_front();
          if (got.changed !== want.changed || got.found !== want.found ||
              got.read_item !== want.read_item ||
              got.list_length !== want.list_length ||
              got.effective_size !== want.effective_size) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display({"%0t: mismatch (expected/actual) changed %0b/%0b found %0b/%0b",
                        " item %h/%h length %0d/%0d size %0d/%0d"}, $time,
                       want.changed, got.changed, want.found, got.found,
                       want.read_item, got.read_item, want.list_length,
                       got.list_length, want.effective_size, got.effective_size);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = mru_apply(in_command, in_item_id, in_index);
        mru_expected.push_back(want);
        beats_per_cmd[in_command]++;
        if (want.found) read_hits++;
      end
      if (cfg_valid && cfg_ready) mru_history = cfg_data;
      if ((out_valid && !out_stall) || (in_valid && !in_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
  end

  // Abort a run that stops moving beats
  initial begin : watchdog
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // Drive the result stall: random stalls, plus one long hold on request
  initial begin : result_stall
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        repeat (HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end
      out_stall <= !no_idle && ($urandom_range(99) < 6);
    end
  end

  // Offer one command beat and hold it until accepted; returns on a falling edge
  task automatic send_beat(input mtf_pkg::mtf_cmd_t cmd, input logic [ITEM_W-1:0] id,
                           input logic [INDEX_W-1:0] idx);
    while (!no_idle && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_item_id <= id;
    in_index   <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Stop offering and wait until every expected result has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (mru_expected.size() != 0) @(negedge clk);
  endtask

  // Write the capacity register once the block is idle
  task automatic write_history(input logic [HS_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    n_settings++;
  endtask

  // Refill the id pool; a small pool gives many hits on listed items
  task automatic fill_id_pool(input int n);
    pool_size = n;
    for (int i = 0; i < POOL_MAX; i++)
      case ($urandom_range(7))
        0:       id_pool[i] = '0;
        1:       id_pool[i] = '1;
        default: id_pool[i] = ITEM_W'($urandom);
      endcase
  endtask

  // One random command beat, mostly adds and reads on pooled ids
  task automatic send_random_beat();
    int                 pick;
    mtf_pkg::mtf_cmd_t  cmd;
    logic [ITEM_W-1:0]  id;
    logic [INDEX_W-1:0] idx;
    pick = $urandom_range(99);
    if (pick < 50)      cmd = mtf_pkg::CMD_ADD;
    else if (pick < 65) cmd = mtf_pkg::CMD_REMOVE;
    else if (pick < 68) cmd = mtf_pkg::CMD_CLEAR;
    else                cmd = mtf_pkg::CMD_READ;
    id  = ($urandom_range(9) == 0) ? ITEM_W'($urandom) : id_pool[$urandom_range(pool_size - 1)];
    idx = ($urandom_range(6) == 0) ? INDEX_W'($urandom) : INDEX_W'($urandom_range(DEPTH + 1));
    send_beat(cmd, id, idx);
  endtask

  // Empty-list cases, head re-add, move of an earlier copy, reads at the edges
  task automatic test_directed_basics();
    send_beat(mtf_pkg::CMD_READ,   16'h0000, 8'd0);
    send_beat(mtf_pkg::CMD_CLEAR,  16'h0000, 8'd0);
    send_beat(mtf_pkg::CMD_REMOVE, 16'h1234, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,    16'h0000, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,    16'hFFFF, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,    16'hFFFF, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,    16'h0000, 8'd0);
    send_beat(mtf_pkg::CMD_READ,   16'h0000, 8'd0);
    send_beat(mtf_pkg::CMD_READ,   16'h0000, 8'd1);
    send_beat(mtf_pkg::CMD_READ,   16'h0000, 8'd2);
    send_beat(mtf_pkg::CMD_READ,   16'hFFFF, 8'd255);
    send_beat(mtf_pkg::CMD_REMOVE, 16'hFFFF, 8'd0);
    send_beat(mtf_pkg::CMD_REMOVE, 16'hFFFF, 8'd0);
    send_beat(mtf_pkg::CMD_CLEAR,  16'h0000, 8'd0);
  endtask

  // Size zero raised to one, size above depth, size lowered below the length
  task automatic test_capacity_edges();
    write_history(5'd0);
    send_beat(mtf_pkg::CMD_ADD,  16'hA5A5, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,  16'h5A5A, 8'd0);
    send_beat(mtf_pkg::CMD_READ, 16'h0000, 8'd0);
    send_beat(mtf_pkg::CMD_READ, 16'h0000, 8'd1);
    write_history(5'd31);
    send_beat(mtf_pkg::CMD_ADD,  16'h0001, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,  16'h8000, 8'd0);
    send_beat(mtf_pkg::CMD_ADD,  16'h7FFE, 8'd0);
    write_history(5'd2);
    send_beat(mtf_pkg::CMD_ADD,  16'h1234, 8'd0);
    send_beat(mtf_pkg::CMD_READ, 16'h0000, 8'd3);
  endtask

  // Random phases over a spread of sizes; the list carries over between them
  task automatic test_random_settings();
    logic [HS_W-1:0] settings [7] = '{5'd16, 5'd0, 5'd31, 5'd1, 5'd10, 5'd5, 5'd2};
    for (int s = 0; s < 7; s++) begin
      write_history(settings[s]);
      fill_id_pool($urandom_range(4, POOL_MAX));
      no_idle = (s == 2);
      repeat (PHASE_BEATS) send_random_beat();
    end
    drain_results();
    no_idle = 1'b0;
  endtask

  // Hold the result side off for a long stretch while commands keep coming
  task automatic test_output_hold();
    fill_id_pool(POOL_MAX);
    hold_pending = 1'b1;
    repeat (16) send_random_beat();
    drain_results();
  endtask

  // Pause the sender until all results are in, then carry on
  task automatic test_pause_and_resume();
    repeat (20) send_random_beat();
    drain_results();
    repeat (20) send_random_beat();
    drain_results();
  endtask

  // Final phase at a random size
  task automatic test_random_capacity();
    write_history(HS_W'($urandom_range(31)));
    fill_id_pool($urandom_range(2, POOL_MAX));
    repeat (100) send_random_beat();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_command = mtf_pkg::CMD_ADD;
    in_item_id = '0;
    in_index   = '0;
    cfg_valid  = 1'b0;
    cfg_data   = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_basics();
    test_capacity_edges();
    test_random_settings();
    test_output_hold();
    test_pause_and_resume();
    test_random_capacity();

    // let any stray result show up before closing
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d adds, %0d removes, %0d clears, %0d reads (%0d hits)",
             beats_per_cmd[mtf_pkg::CMD_ADD], beats_per_cmd[mtf_pkg::CMD_REMOVE],
             beats_per_cmd[mtf_pkg::CMD_CLEAR], beats_per_cmd[mtf_pkg::CMD_READ],
             read_hits);
    $display("over %0d capacity settings, one long output hold, %0d failures",
             n_settings, fail_count);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/mtf_pkg.sv
design/mtf_mem.sv
design/mtf_core.sv
design/bounded_move_to_front_list.sv
design/mtf_chk.sv
dv/tb_top.sv
